/* src/erssd_pkg.sv */
// ----------------------------------------------------------------------------
// erssd_pkg - echo range seven segment display shared definitions
// item types, conversion constants and the digit decode tables
// ----------------------------------------------------------------------------
package erssd_pkg;

    localparam int unsigned DIST_W   = 14;
    localparam int unsigned WIDTH_W  = 15;
    localparam int unsigned POS_W    = 2;
    localparam int unsigned SEG_W    = 7;

    // echo width to millimetres: floor(w * 343 / 2000) == (w * CONV_RECIP) >> CONV_SHIFT
    // exact for every 15-bit width
    localparam int unsigned CONV_SHIFT = 26;
    localparam int unsigned CONV_RECIP_W = 24;
    localparam logic [CONV_RECIP_W-1:0] CONV_RECIP = 24'd11509171;

    localparam logic [DIST_W-1:0] DIST_MAX     = 14'd9999;
    localparam logic [DIST_W-1:0] THRESH_RESET = 14'd200;

    // decimal digit split: floor(v / d) == (v * recip) >> DIGIT_SHIFT for v < 2**14
    localparam int unsigned DIGIT_SHIFT   = 24;
    localparam int unsigned DIGIT_RECIP_W = 25;
    localparam logic [DIGIT_RECIP_W-1:0] RECIP_1000 = 25'd16778;
    localparam logic [DIGIT_RECIP_W-1:0] RECIP_100  = 25'd167773;
    localparam logic [DIGIT_RECIP_W-1:0] RECIP_10   = 25'd1677722;
    localparam logic [DIGIT_RECIP_W-1:0] RECIP_1    = 25'd16777216;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // display positions, most significant first
    typedef enum logic [POS_W-1:0] {
        POS_THOUSANDS = 2'd0,
        POS_HUNDREDS  = 2'd1,
        POS_TENS      = 2'd2,
        POS_UNITS     = 2'd3
    } t_pos;

    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_SCAN    = 1'b1
    } t_opcode;

    typedef struct packed {
        logic               opcode;
        logic [WIDTH_W-1:0] echo_width_us;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  digit_index;
        logic [SEG_W-1:0]  segment_pattern;
        logic [DIST_W-1:0] distance_mm;
        logic              buzzer_on;
    } t_out_item;

    // converted measurement handed from the converter to the top level
    typedef struct packed {
        logic [DIST_W-1:0] dist_mm;
        logic              alarm;
    } t_meas;

    // reciprocal for the divisor that isolates a display position
    function automatic logic [DIGIT_RECIP_W-1:0] digit_recip(input logic [POS_W-1:0] pos);
        logic [DIGIT_RECIP_W-1:0] r;
        case (pos)
            POS_THOUSANDS: r = RECIP_1000;
            POS_HUNDREDS:  r = RECIP_100;
            POS_TENS:      r = RECIP_10;
            POS_UNITS:     r = RECIP_1;
            default:       r = RECIP_1;
        endcase
        return r;
    endfunction

    // segments a..g in bits 0..6, 1 lit
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h6F;
        endcase
        return s;
    endfunction

endpackage

/* src/erssd_conv.sv */
// ----------------------------------------------------------------------------
// erssd_conv - echo width to distance converter
// scales the echo width to millimetres, applies timeout and clamp,
// and compares the result against the alarm threshold
// ----------------------------------------------------------------------------
module erssd_conv (
    input  logic [erssd_pkg::WIDTH_W-1:0] i_echo_width_us,
    input  logic [erssd_pkg::DIST_W-1:0]  i_threshold_mm,
    output erssd_pkg::t_meas              o_meas
);

    localparam int unsigned PROD_W = erssd_pkg::WIDTH_W + erssd_pkg::CONV_RECIP_W;
    localparam int unsigned QUO_W  = PROD_W - erssd_pkg::CONV_SHIFT;

    logic [PROD_W-1:0]             prod;
    logic [QUO_W-1:0]              quo;
    logic [erssd_pkg::DIST_W-1:0]  clamped_mm;

    // width * 343 / 2000 through a reciprocal multiply
    assign prod = PROD_W'(i_echo_width_us) * PROD_W'(erssd_pkg::CONV_RECIP);
    assign quo  = prod[PROD_W-1:erssd_pkg::CONV_SHIFT];

    // timeout reads as full scale, otherwise clamp
    always_comb begin
        if (i_echo_width_us == '0) begin
            clamped_mm = erssd_pkg::DIST_MAX;
        end else if (erssd_pkg::DIST_W'(quo) > erssd_pkg::DIST_MAX) begin
            clamped_mm = erssd_pkg::DIST_MAX;
        end else begin
            clamped_mm = erssd_pkg::DIST_W'(quo);
        end
    end

    assign o_meas.dist_mm = clamped_mm;
    assign o_meas.alarm   = (clamped_mm <= i_threshold_mm);

endmodule

/* src/echo_range_seven_segment_display.sv */
// ----------------------------------------------------------------------------
// echo_range_seven_segment_display - ultrasonic range to four digit display
// converts echo widths to a held distance with a buzzer flag and scans the
// four digits of that distance onto a seven segment pattern
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall      | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall    | o_out_item (t_out_item)
//  cfg      | input     | i_cfg_we, no wait            | i_cfg_data (alarm threshold)
//
//  one item per cycle while the output is not stalled; a taken item passes in order through the
//  input register, measurement register, digit quotient register, result register
//  every stage moves on whenever the stage after it is free or emptying
//  reset clears all stages, held distance, scan position and buzzer; threshold = 200
//  a stalled result holds; up to four items wait in the stages, and o_in_stall
//  rises only when every stage is full and the output is stalled
// ----------------------------------------------------------------------------
module echo_range_seven_segment_display (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [erssd_pkg::DIST_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  erssd_pkg::t_in_item          i_in_item,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output erssd_pkg::t_out_item         o_out_item,
    input  logic                         i_out_stall
);

    localparam int unsigned DW      = erssd_pkg::DIST_W;
    localparam int unsigned PW      = erssd_pkg::POS_W;
    localparam int unsigned QPROD_W = DW + erssd_pkg::DIGIT_RECIP_W;
    localparam int unsigned MPROD_W = DW + erssd_pkg::DIGIT_RECIP_W;

    // configuration and block state
    logic [DW-1:0] r_thresh;
    logic [DW-1:0] r_held;
    logic [PW-1:0] r_pos;
    logic          r_alarm;

    // stage registers
    logic                r_in_valid;
    erssd_pkg::t_in_item r_in;
    logic                r_s2_valid;
    logic [DW-1:0]       r_s2_dist;
    logic [PW-1:0]       r_s2_pos;
    logic                r_s2_alarm;
    logic                r_s3_valid;
    logic [DW-1:0]       r_s3_quo;
    logic [DW-1:0]       r_s3_dist;
    logic [PW-1:0]       r_s3_pos;
    logic                r_s3_alarm;
    logic                 r_out_valid;
    erssd_pkg::t_out_item r_out;

    logic                 n_in_valid;
    logic                 n_s2_valid;
    logic                 n_s3_valid;
    logic                 n_out_valid;
    logic [DW-1:0]        n_s2_dist;
    logic [PW-1:0]        n_s2_pos;
    logic                 n_s2_alarm;
    logic [DW-1:0]        n_s3_quo;
    erssd_pkg::t_out_item n_out;

    logic             ld_out;
    logic             ld_s3;
    logic             ld_s2;
    logic             take_s2;
    logic             is_scan;
    erssd_pkg::t_meas meas;

    logic [QPROD_W-1:0] qprod;
    logic [MPROD_W-1:0] mprod;
    logic [DW-1:0]      quo10;
    logic [DW-1:0]      rem10;
    logic [3:0]         digit;

    // stage advance, back to front
    assign ld_out     = !r_out_valid || !i_out_stall;
    assign ld_s3      = !r_s3_valid || ld_out;
    assign ld_s2      = !r_s2_valid || ld_s3;
    assign o_in_stall = r_in_valid && !ld_s2;
    assign take_s2    = r_in_valid && ld_s2;
    assign is_scan    = (r_in.opcode == erssd_pkg::OP_SCAN);

    // measurement conversion
    erssd_conv u_conv (
        .i_echo_width_us (r_in.echo_width_us),
        .i_threshold_mm  (r_thresh),
        .o_meas          (meas)
    );

    // state after this item
    always_comb begin
        if (is_scan) begin
            n_s2_dist  = r_held;
            n_s2_pos   = r_pos + PW'(1);
            n_s2_alarm = r_alarm;
        end else begin
            n_s2_dist  = meas.dist_mm;
            n_s2_pos   = r_pos;
            n_s2_alarm = meas.alarm;
        end
    end

    // quotient that brings the shown digit to the units place
    assign qprod    = QPROD_W'(r_s2_dist) * QPROD_W'(erssd_pkg::digit_recip(r_s2_pos));
    assign n_s3_quo = DW'(qprod[QPROD_W-1:erssd_pkg::DIGIT_SHIFT]);

    // units digit of the quotient, thousands clamped to nine
    assign mprod = MPROD_W'(r_s3_quo) * MPROD_W'(erssd_pkg::RECIP_10);
    assign quo10 = DW'(mprod[MPROD_W-1:erssd_pkg::DIGIT_SHIFT]);
    assign rem10 = r_s3_quo - ((quo10 << 3) + (quo10 << 1));

    always_comb begin
        if (r_s3_pos == erssd_pkg::POS_THOUSANDS) begin
            digit = (r_s3_quo > DW'(erssd_pkg::DIGIT_MAX)) ? erssd_pkg::DIGIT_MAX
                                                          : r_s3_quo[3:0];
        end else begin
            digit = rem10[3:0];
        end
        n_out.digit_index     = r_s3_pos;
        n_out.segment_pattern = erssd_pkg::seg_of(digit);
        n_out.distance_mm     = r_s3_dist;
        n_out.buzzer_on       = r_s3_alarm;
    end

    // next valid flags
    always_comb begin
        n_in_valid  = o_in_stall ? r_in_valid : i_in_valid;
        n_s2_valid  = ld_s2  ? r_in_valid : r_s2_valid;
        n_s3_valid  = ld_s3  ? r_s2_valid : r_s3_valid;
        n_out_valid = ld_out ? r_s3_valid : r_out_valid;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_thresh    <= erssd_pkg::THRESH_RESET;
            r_held      <= '0;
            r_pos       <= erssd_pkg::POS_THOUSANDS;
            r_alarm     <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_s2_valid  <= n_s2_valid;
            r_s3_valid  <= n_s3_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (take_s2) begin
                r_held  <= n_s2_dist;
                r_pos   <= n_s2_pos;
                r_alarm <= n_s2_alarm;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
        if (ld_s2) begin
            r_s2_dist  <= n_s2_dist;
            r_s2_pos   <= n_s2_pos;
            r_s2_alarm <= n_s2_alarm;
        end
        if (ld_s3) begin
            r_s3_quo   <= n_s3_quo;
            r_s3_dist  <= r_s2_dist;
            r_s3_pos   <= r_s2_pos;
            r_s3_alarm <= r_s2_alarm;
        end
        if (ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* src/erssd_checker.sv */
// ----------------------------------------------------------------------------
// erssd_checker - port level checks for the range display
// watches the top level ports and flags results that cannot occur
// ----------------------------------------------------------------------------
module erssd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input erssd_pkg::t_in_item          i_in_item,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input erssd_pkg::t_out_item         o_out_item,
    input logic                         i_out_stall
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input item changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // held distance never passes full scale
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.distance_mm <= erssd_pkg::DIST_MAX)
        else $error("distance out of range");

    // every decimal digit lights at least two segments
    a_seg_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$onehot0(o_out_item.segment_pattern))
        else $error("segment pattern is not a digit");

endmodule

bind echo_range_seven_segment_display erssd_checker u_erssd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
